// File: hw/rtl/assert_macros.svh
// Concurrent assertion macros shared by the edge dedup filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/edpdf_pkg.sv
// Types and constants shared by the edge pair dedup filter.
`default_nettype none

package edpdf_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int VERTEX_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KEY_BITS    = 2 * VERTEX_BITS;

   typedef logic [VERTEX_BITS-1:0] vertex_type;
   typedef logic [KEY_BITS-1:0]    key_type;
   typedef logic [CNT_BITS-1:0]    count_type;
   typedef logic [IDX_BITS-1:0]    index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] vertex_a;
      logic [FIELD_BITS-1:0] vertex_b;
      logic                  first_of_list;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] low_vertex;
      logic [FIELD_BITS-1:0] high_vertex;
      logic                  not_remembered;
   } rsp_type;

   // Registered request, already ordered.
   typedef struct packed {
      logic       vld;
      logic       clear;
      vertex_type lo;
      vertex_type hi;
   } stage_type;

   typedef struct packed {
      logic    commit;
      logic    clear;
      key_type key;
   } cam_req_type;

   typedef struct packed {
      logic hit;
      logic full;
   } cam_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/edpdf_input_stage.sv
// Input register: masks and orders the vertex pair of each request.
`default_nettype none

module edpdf_input_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire edpdf_pkg::req_type  req,
   output logic                     req_stall,
   input  wire logic                advance,
   output edpdf_pkg::stage_type     stage
);
   import edpdf_pkg::*;
   `include "assert_macros.svh"

   logic       vld_ff, vld_in;
   logic       clear_ff;
   vertex_type lo_ff, hi_ff;
   vertex_type va, vb;
   logic       load;

   assign va        = vertex_type'(req.vertex_a);
   assign vb        = vertex_type'(req.vertex_b);
   assign req_stall = vld_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         clear_ff <= req.first_of_list;
         lo_ff    <= (va < vb) ? va : vb;
         hi_ff    <= (va < vb) ? vb : va;
      end
   end

   assign stage.vld   = vld_ff;
   assign stage.clear = clear_ff;
   assign stage.lo    = lo_ff;
   assign stage.hi    = hi_ff;

   `ASSERT_ALWAYS(a_ordered, clock, reset, !vld_ff || (lo_ff <= hi_ff), "pair not ordered")
   `ASSERT_NEXT(a_hold, clock, reset, vld_ff && !advance,
                vld_ff && $stable(lo_ff) && $stable(hi_ff) && $stable(clear_ff),
                "held request changed")

endmodule

`default_nettype wire

// File: hw/rtl/edpdf_cam.sv
// Parallel-compare table of ordered edge pairs with fill count.
`default_nettype none

module edpdf_cam (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire edpdf_pkg::cam_req_type  cam_req,
   output edpdf_pkg::cam_status_type    status
);
   import edpdf_pkg::*;
   `include "assert_macros.svh"

   key_type                entries_ff [TABLE_DEPTH];
   count_type              count_ff, count_in;
   count_type              eff_count;
   logic [TABLE_DEPTH-1:0] match;
   logic                   hit, full, wr_en;

   assign eff_count = cam_req.clear ? '0 : count_ff;
   assign full      = (eff_count >= count_type'(TABLE_DEPTH));

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = (count_type'(i) < eff_count) && (entries_ff[i] == cam_req.key);
      end
   end

   assign hit   = |match;
   assign wr_en = cam_req.commit && !hit && !full;

   always_comb begin
      count_in = count_ff;
      if (cam_req.commit) begin
         count_in = wr_en ? count_type'(eff_count + 1'b1) : eff_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[eff_count[IDX_BITS-1:0]] <= cam_req.key;
      end
   end

   assign status.hit  = hit;
   assign status.full = full;

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= count_type'(TABLE_DEPTH),
                  "fill count past depth")
   `ASSERT_NEXT(a_count_step, clock, reset, wr_en,
                count_ff == count_type'($past(eff_count) + 1'b1), "store did not advance count")

endmodule

`default_nettype wire

// File: hw/rtl/edge_pair_dedup_filter_core.sv
// Top level of the undirected edge pair dedup filter.
//
// Requests carry one edge (vertex_a, vertex_b, first_of_list) on req_valid /
// req_stall; a request is taken when req_valid is high and req_stall is low.
// Each edge is ordered low/high and looked up in a 64-entry compare table.
// A new edge is stored and returned on rsp_valid / rsp_stall; an edge already
// in the table returns nothing. first_of_list empties the table first. When
// the table is full, new edges are returned with not_remembered set.
// Each request passes the input register, then the response register; the
// lookup and the table write happen in the same cycle.
// Throughput: one request per cycle while no held response stalls the input.
// Reset empties the table and drops any held request or response; no
// clearing pass is needed. While rsp_stall holds a response, one more request
// is taken into the input register; req_stall rises after that, except that
// a duplicate edge still drains since it makes no response.
`default_nettype none

module edge_pair_dedup_filter_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire edpdf_pkg::req_type  req,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output edpdf_pkg::rsp_type       rsp
);
   import edpdf_pkg::*;
   `include "assert_macros.svh"

   stage_type      stage;
   cam_req_type    cam_req;
   cam_status_type status;
   logic           advance, rsp_load;
   logic           rsp_vld_ff, rsp_vld_in;
   rsp_type        rsp_ff;

   edpdf_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .advance   (advance),
      .stage     (stage)
   );

   assign advance = stage.vld && (status.hit || !rsp_vld_ff || !rsp_stall);
   assign rsp_load = advance && !status.hit;

   assign cam_req.commit = advance;
   assign cam_req.clear  = stage.clear;
   assign cam_req.key    = {stage.hi, stage.lo};

   edpdf_cam u_cam (
      .clock   (clock),
      .reset   (reset),
      .cam_req (cam_req),
      .status  (status)
   );

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.low_vertex     <= FIELD_BITS'(stage.lo);
         rsp_ff.high_vertex    <= FIELD_BITS'(stage.hi);
         rsp_ff.not_remembered <= status.full;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

   `ASSERT_NEXT(a_new_edge_out, clock, reset, rsp_load, rsp_vld_ff,
                "new edge produced no response")

endmodule

`default_nettype wire

// File: test/tb_edge_pair_dedup_filter_core.sv
// Testbench for the edge pair dedup filter: directed and random edge lists checked against a scoreboard.
`default_nettype none

module tb_edge_pair_dedup_filter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import edpdf_pkg::*;

   localparam int TOTAL_REQUESTS = 900;
   localparam int CYCLE_LIMIT    = 200000;

   class edge_dedup_scoreboard;
      key_type     edge_table[TABLE_DEPTH];
      int unsigned table_fill = 0;
      rsp_type     unique_edges_due[$];
      int          errors = 0;

      function void note_request(req_type r);
         vertex_type a;
         vertex_type b;
         vertex_type lo;
         vertex_type hi;
         key_type    k;
         bit         hit;
         rsp_type    e;
         a = vertex_type'(r.vertex_a);
         b = vertex_type'(r.vertex_b);
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         k = {hi, lo};
         if (r.first_of_list)
            table_fill = 0;
         hit = 1'b0;
         for (int i = 0; i < table_fill; i++)
            if (edge_table[i] == k)
               hit = 1'b1;
         if (hit)
            return;
         e.low_vertex = lo;
         e.high_vertex = hi;
         e.not_remembered = (table_fill >= TABLE_DEPTH);
         if (!e.not_remembered) begin
            edge_table[table_fill] = k;
            table_fill++;
         end
         unique_edges_due = {unique_edges_due, e};
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (unique_edges_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, r);
            errors++;
            return;
         end
         e = unique_edges_due.pop_front();
         if (r.low_vertex !== e.low_vertex) begin
            $display("%0t: low_vertex expected %h actual %h", $time, e.low_vertex,
                     r.low_vertex);
            errors++;
         end
         if (r.high_vertex !== e.high_vertex) begin
            $display("%0t: high_vertex expected %h actual %h", $time, e.high_vertex,
                     r.high_vertex);
            errors++;
         end
         if (r.not_remembered !== e.not_remembered) begin
            $display("%0t: not_remembered expected %b actual %b", $time,
                     e.not_remembered, r.not_remembered);
            errors++;
         end
      endfunction

      function int pending();
         return unique_edges_due.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   edge_dedup_scoreboard sb = new;

   int sent_count = 0;
   int cycles = 0;
   int stall_left = 0;
   bit tx_burst = 1'b0;
   bit rx_quiet = 1'b0;

   edge_pair_dedup_filter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: check accepted responses, then draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp);
            stall_left = rx_quiet ? 0 : $urandom_range(0, 9);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_edge(input vertex_type a, input vertex_type b, input bit first);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= '{vertex_a: a, vertex_b: b, first_of_list: first};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request('{vertex_a: a, vertex_b: b, first_of_list: first});
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic vertex_type pick_vertex();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return vertex_type'(1) << (VERTEX_BITS - 1);
         3: return ~(vertex_type'(1) << (VERTEX_BITS - 1));
         default: return vertex_type'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      vertex_type pool[14];
      int         pool_n;
      int         len;
      int         kind;
      bit         first;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ordering, duplicates, self-loops, clear
      send_edge(16'h0000, 16'h0000, 1'b0);
      send_edge(16'hFFFF, 16'hFFFF, 1'b0);
      send_edge(16'hFFFF, 16'h0000, 1'b0);
      send_edge(16'h0000, 16'hFFFF, 1'b0);
      send_edge(16'h0005, 16'h0003, 1'b0);
      send_edge(16'h0003, 16'h0005, 1'b0);
      send_edge(16'h0000, 16'h0000, 1'b0);
      send_edge(16'hAAAA, 16'h5555, 1'b0);
      send_edge(16'h5555, 16'hAAAA, 1'b1);
      send_edge(16'h0000, 16'h0000, 1'b0);
      send_edge(16'h1234, 16'h1234, 1'b0);
      send_edge(16'h1234, 16'h1234, 1'b0);
      send_edge(16'h8000, 16'h7FFF, 1'b0);
      drain();

      while (sent_count < TOTAL_REQUESTS) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // edge list over a small vertex pool: many repeats, often a full table
            pool_n = $urandom_range(2, 14);
            for (int i = 0; i < pool_n; i++)
               pool[i] = pick_vertex();
            len = $urandom_range(5, 130);
            for (int i = 0; i < len && sent_count < TOTAL_REQUESTS; i++) begin
               first = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 40) == 0);
               send_edge(pool[$urandom_range(0, pool_n - 1)],
                         pool[$urandom_range(0, pool_n - 1)], first);
            end
         end else if (kind < 9) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len && sent_count < TOTAL_REQUESTS; i++)
               send_edge(vertex_type'($urandom), vertex_type'($urandom),
                         ($urandom_range(0, 3) == 0));
         end else begin
            drain();
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
